@@ hw/rtl/stes_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stes_pkg
// Shared widths, opcodes and the result bundle for the sorted table search.
// ----------------------------------------------------------------------------
package stes_pkg;

   localparam int KEY_W = 32;
   localparam int IDX_W = 10;
   localparam int POS_W = 11;
   localparam int DEF_TABLE_DEPTH = 1024;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [IDX_W-1:0] first_index;
      logic [POS_W-1:0] match_count;
   } result_type;

endpackage
`default_nettype wire

@@ hw/rtl/stes_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stes_mem
// Key table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stes_mem #(
   parameter int TABLE_DEPTH = stes_pkg::DEF_TABLE_DEPTH
) (
   input  wire                                 clock,
   input  wire                                 wr_en,
   input  wire  [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
   input  wire  signed [stes_pkg::KEY_W-1:0]   wr_data,
   input  wire  [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
   output logic signed [stes_pkg::KEY_W-1:0]   rd_data
);

   logic signed [stes_pkg::KEY_W-1:0] keys [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= keys[rd_addr];
   end

endmodule
`default_nettype wire

@@ hw/rtl/stes_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stes_ctrl
// Search sequencer: binary probe, end checks, then backward and forward
// scans over equal neighbors. Every probe is a read state and an evaluate state.
// ----------------------------------------------------------------------------
module stes_ctrl #(
   parameter int TABLE_DEPTH = stes_pkg::DEF_TABLE_DEPTH
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire  signed [stes_pkg::KEY_W-1:0]   start_key,
   input  wire  [stes_pkg::POS_W-1:0]          entry_count,
   output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
   input  wire  signed [stes_pkg::KEY_W-1:0]   rd_data,
   input  wire                                 res_ready,
   output stes_pkg::result_type                res,
   output logic                                busy
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int POS_W  = stes_pkg::POS_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PR_RD = 4'd1;
   localparam logic [3:0] S_PR_EV = 4'd2;
   localparam logic [3:0] S_HI_RD = 4'd3;
   localparam logic [3:0] S_HI_EV = 4'd4;
   localparam logic [3:0] S_LO_RD = 4'd5;
   localparam logic [3:0] S_LO_EV = 4'd6;
   localparam logic [3:0] S_BK_RD = 4'd7;
   localparam logic [3:0] S_BK_EV = 4'd8;
   localparam logic [3:0] S_FW_RD = 4'd9;
   localparam logic [3:0] S_FW_EV = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   logic [3:0]                        state_ff, state_in;
   logic [POS_W-1:0]                  lo_ff, lo_in;
   logic [POS_W-1:0]                  hi_ff, hi_in;
   logic [POS_W-1:0]                  mid_ff, mid_in;
   logic [POS_W-1:0]                  first_ff, first_in;
   logic [POS_W-1:0]                  last_ff, last_in;
   logic [POS_W-1:0]                  n_ff, n_in;
   logic                              found_ff, found_in;
   logic signed [stes_pkg::KEY_W-1:0] tgt_ff, tgt_in;

   logic [POS_W-1:0] n_sat;
   logic [POS_W-1:0] step_lo, step_hi;
   logic [POS_W:0]   step_sum;
   logic [POS_W:0]   last_next;
   logic             key_eq;
   logic [POS_W-1:0] rd_pos;

   assign n_sat = (32'(entry_count) > 32'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH) : entry_count;
   assign key_eq = (tgt_ff == rd_data);
   assign last_next = {1'b0, last_ff} + 1'b1;

   // narrow the probe window by the key just read
   always_comb begin
      if (tgt_ff < rd_data) begin
         step_lo = lo_ff;
         step_hi = mid_ff;
      end else begin
         step_lo = mid_ff;
         step_hi = hi_ff;
      end
      step_sum = {1'b0, step_hi} + {1'b0, step_lo};
   end

   always_comb begin
      unique case (state_ff)
         S_HI_RD: rd_pos = hi_ff;
         S_LO_RD: rd_pos = lo_ff;
         S_BK_RD: rd_pos = first_ff - 1'b1;
         S_FW_RD: rd_pos = last_next[POS_W-1:0];
         default: rd_pos = mid_ff;
      endcase
   end

   assign rd_addr = ADDR_W'(rd_pos);

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      first_in = first_ff;
      last_in  = last_ff;
      n_in     = n_ff;
      found_in = found_ff;
      tgt_in   = tgt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               tgt_in   = start_key;
               n_in     = n_sat;
               lo_in    = '0;
               hi_in    = n_sat - 1'b1;
               mid_in   = (n_sat - 1'b1) >> 1;
               first_in = '0;
               last_in  = '0;
               found_in = 1'b0;
               if (n_sat == '0) begin
                  state_in = S_DONE;
               end else if (n_sat - 1'b1 > POS_W'(1)) begin
                  state_in = S_PR_RD;
               end else begin
                  state_in = S_HI_RD;
               end
            end
         end
         S_PR_RD: state_in = S_PR_EV;
         S_PR_EV: begin
            if (key_eq) begin
               first_in = mid_ff;
               found_in = 1'b1;
               state_in = S_HI_RD;
            end else begin
               lo_in  = step_lo;
               hi_in  = step_hi;
               mid_in = step_sum[POS_W:1];
               state_in = (step_hi - step_lo > POS_W'(1)) ? S_PR_RD : S_HI_RD;
            end
         end
         S_HI_RD: state_in = S_HI_EV;
         S_HI_EV: begin
            if (key_eq) begin
               first_in = hi_ff;
               last_in  = hi_ff;
               found_in = 1'b1;
               state_in = S_BK_RD;
            end else begin
               state_in = S_LO_RD;
            end
         end
         S_LO_RD: state_in = S_LO_EV;
         S_LO_EV: begin
            if (key_eq) begin
               first_in = lo_ff;
               last_in  = lo_ff;
               found_in = 1'b1;
               state_in = S_BK_RD;
            end else if (found_ff) begin
               last_in  = first_ff;
               state_in = S_BK_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BK_RD: state_in = (first_ff == '0) ? S_FW_RD : S_BK_EV;
         S_BK_EV: begin
            if (key_eq) begin
               first_in = first_ff - 1'b1;
               state_in = S_BK_RD;
            end else begin
               state_in = S_FW_RD;
            end
         end
         S_FW_RD: state_in = (last_next < {1'b0, n_ff}) ? S_FW_EV : S_DONE;
         S_FW_EV: begin
            if (key_eq) begin
               last_in  = last_next[POS_W-1:0];
               state_in = S_FW_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register frees up
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      n_ff     <= n_in;
      found_ff <= found_in;
      tgt_ff   <= tgt_in;
   end

   always_comb begin
      res.valid = (state_ff == S_DONE);
      res.found = found_ff;
      if (found_ff) begin
         res.first_index = first_ff[stes_pkg::IDX_W-1:0];
         res.match_count = last_ff - first_ff + 1'b1;
      end else begin
         res.first_index = '0;
         res.match_count = '0;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

@@ hw/rtl/sorted_table_equal_range_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Write item: accepted while not busy, no result, next item the cycle after.
// Query item: p binary probes (at most ceil(log2(n)), n the entries in use), then
// the end check on the high entry and, unless it hits, the low one; a hit adds a
// backward and a forward scan over equal neighbors. Each probe or scan step is a
// read and a compare. One item is in work at a time; a stalled result holds the
// input. Reset clears the entry count and the result valid flag, not the table.
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search
// Sorted key table with binary search and equal-range report.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search #(
   parameter int TABLE_DEPTH = stes_pkg::DEF_TABLE_DEPTH
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wr_en,
   input  wire  [stes_pkg::POS_W-1:0]          csr_wr_data,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_op,
   input  wire  [stes_pkg::IDX_W-1:0]          req_entry_index,
   input  wire  signed [stes_pkg::KEY_W-1:0]   req_key,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic                                rsp_found,
   output logic [stes_pkg::IDX_W-1:0]          rsp_first_index,
   output logic [stes_pkg::POS_W-1:0]          rsp_match_count
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic [stes_pkg::POS_W-1:0]        count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              found_ff;
   logic [stes_pkg::IDX_W-1:0]        first_ff;
   logic [stes_pkg::POS_W-1:0]        match_ff;

   logic                              busy;
   logic                              req_take;
   logic                              start;
   logic                              wr_en;
   logic [ADDR_W-1:0]                 rd_addr;
   logic signed [stes_pkg::KEY_W-1:0] rd_data;
   logic                              res_ready;
   logic                              res_load;
   stes_pkg::result_type              res;

   assign req_stall = busy;
   assign req_take  = req_valid && !req_stall;
   assign start     = req_take && (req_op == stes_pkg::OP_QUERY);
   // drop writes beyond the table
   assign wr_en     = req_take && (req_op == stes_pkg::OP_WRITE)
                      && (32'(req_entry_index) < 32'(TABLE_DEPTH));

   assign res_ready = !rsp_valid_ff || !rsp_stall;
   assign res_load  = res.valid && res_ready;

   assign count_in     = csr_wr_en ? csr_wr_data : count_ff;
   assign rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         found_ff <= res.found;
         first_ff <= res.first_index;
         match_ff <= res.match_count;
      end
   end

   stes_mem #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (req_key),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stes_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_key   (req_key),
      .entry_count (count_ff),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .res_ready   (res_ready),
      .res         (res),
      .busy        (busy)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_first_index = first_ff;
   assign rsp_match_count = match_ff;

endmodule
`default_nettype wire
